### hw/rtl/kpirq_pkg.sv
// ----------------------------------------------------------------------------
// Keypad IRQ package
// Shared widths, key positions, register indexes and the result type.
// ----------------------------------------------------------------------------
package kpirq_pkg;

    localparam int KEY_COUNT = 10;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = KEY_COUNT;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 16;

    typedef logic [KEY_COUNT-1:0] key_vec_t;

    // Key bit positions, in the register's order.
    localparam logic [IDX_W-1:0] KEY_A      = 4'd0;
    localparam logic [IDX_W-1:0] KEY_B      = 4'd1;
    localparam logic [IDX_W-1:0] KEY_SELECT = 4'd2;
    localparam logic [IDX_W-1:0] KEY_START  = 4'd3;
    localparam logic [IDX_W-1:0] KEY_RIGHT  = 4'd4;
    localparam logic [IDX_W-1:0] KEY_LEFT   = 4'd5;
    localparam logic [IDX_W-1:0] KEY_UP     = 4'd6;
    localparam logic [IDX_W-1:0] KEY_DOWN   = 4'd7;
    localparam logic [IDX_W-1:0] KEY_R      = 4'd8;
    localparam logic [IDX_W-1:0] KEY_L      = 4'd9;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_ALL_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_KEY_SELECT = 2'd2;

    // Item kinds.
    localparam logic KIND_BUTTON = 1'b0;
    localparam logic KIND_CHECK  = 1'b1;

    typedef struct packed {
        logic     irq_request;
        key_vec_t key_bits;
    } result_t;

    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } obuf_status_t;

endpackage

### hw/rtl/kpirq_core.sv
// ----------------------------------------------------------------------------
// Keypad IRQ core
// Configuration and key state registers, event update and interrupt edge.
// ----------------------------------------------------------------------------
module kpirq_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kpirq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kpirq_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           item_take,
    input  logic                           item_kind,
    input  logic [kpirq_pkg::IDX_W-1:0]     item_button,
    input  logic                           item_pressed,
    output kpirq_pkg::result_t             result
);
    import kpirq_pkg::*;

    logic     irq_enable_reg;
    logic     irq_all_mode_reg;
    key_vec_t irq_key_select_reg;

    key_vec_t key_reg;
    key_vec_t key_next;
    key_vec_t supp_reg;
    key_vec_t supp_next;
    logic     cond_reg;
    logic     cond_next;

    key_vec_t bit_mask;
    key_vec_t opp_mask;
    key_vec_t supp_rel;
    key_vec_t held;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_enable_reg     <= 1'b0;
            irq_all_mode_reg   <= 1'b0;
            irq_key_select_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IRQ_ENABLE:     irq_enable_reg     <= cfg_data[0];
                CFG_IRQ_ALL_MODE:   irq_all_mode_reg   <= cfg_data[0];
                CFG_IRQ_KEY_SELECT: irq_key_select_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        bit_mask = '0;
        if (item_button < IDX_W'(KEY_COUNT))
        begin
            bit_mask = key_vec_t'(1) << item_button;
        end
        case (item_button) inside
            KEY_RIGHT, KEY_UP:  opp_mask = bit_mask << 1;
            KEY_LEFT, KEY_DOWN: opp_mask = bit_mask >> 1;
            default:            opp_mask = '0;
        endcase

        key_next = key_reg;
        supp_next = supp_reg;
        supp_rel = supp_reg & ~bit_mask;
        if (item_kind == KIND_BUTTON)
        begin
            if (item_pressed)
            begin
                // A direction press releases its opposite and remembers
                // whether the opposite was held at that moment.
                supp_next = supp_reg | (~key_reg & opp_mask);
                key_next  = (key_reg | opp_mask) & ~bit_mask;
            end
            else if (opp_mask != '0)
            begin
                key_next  = (key_reg & ~(supp_rel & opp_mask)) | bit_mask;
                supp_next = supp_rel & ~opp_mask;
            end
            else
            begin
                key_next = key_reg | bit_mask;
            end
        end

        held = irq_key_select_reg & ~key_next;
        if (!irq_enable_reg)
        begin
            cond_next = 1'b0;
        end
        else if (irq_all_mode_reg)
        begin
            cond_next = (held == irq_key_select_reg);
        end
        else
        begin
            cond_next = (held != '0);
        end

        result.key_bits    = key_next;
        result.irq_request = cond_next & ~cond_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '1;
            supp_reg <= '0;
            cond_reg <= 1'b0;
        end
        else if (item_take)
        begin
            key_reg  <= key_next;
            supp_reg <= supp_next;
            cond_reg <= cond_next;
        end
    end

endmodule

### hw/rtl/kpirq_obuf.sv
// ----------------------------------------------------------------------------
// Keypad IRQ output buffer
// Result register with a skid stage so input stays open under a stall.
// ----------------------------------------------------------------------------
module kpirq_obuf (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  kpirq_pkg::result_t       push_data,
    output logic                     push_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    output kpirq_pkg::result_t       out_data,
    output kpirq_pkg::obuf_status_t  status
);
    import kpirq_pkg::*;

    logic    main_valid_reg;
    result_t main_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    assign push_ready        = ~skid_valid_reg;
    assign out_valid         = main_valid_reg;
    assign out_data          = main_data_reg;
    assign status.main_valid = main_valid_reg;
    assign status.skid_valid = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !main_valid_reg)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

### hw/rtl/keypad_state_and_irq_unit.sv
// ----------------------------------------------------------------------------
// Keypad state and interrupt request unit
// Applies button events to an active-low key register and flags new IRQs.
// ----------------------------------------------------------------------------
// The result output is registered. Throughput: one item per cycle while
// the skid entry is free; the key state update is a single pass of
// bitwise logic on ten-bit registers, and a two-entry result buffer keeps
// the slave side open for one more item while the master side stalls.
// Reset: keys all released, no remembered opposites, condition false,
// configuration registers zero, result buffer empty.
module keypad_state_and_irq_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [kpirq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kpirq_pkg::CFG_W-1:0]      cfg_data,
    // Slave side: one event or check item per handshake.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [kpirq_pkg::S_DATA_W-1:0]   s_axis_tdata,  // [3:0] button_index, [4] pressed
    input  logic                            s_axis_tuser,  // [0] kind
    // Master side: one result item per accepted item.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [kpirq_pkg::M_DATA_W-1:0]   m_axis_tdata   // [9:0] key_bits, [10] irq_request
);
    import kpirq_pkg::*;

    logic         item_take;
    result_t      core_result;
    result_t      out_result;
    obuf_status_t obuf_status;

    // An item is taken whenever the skid stage is free; the state registers
    // advance in that same cycle, so back-to-back items see fresh state.
    assign item_take = s_axis_tvalid & s_axis_tready;

    kpirq_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_take    (item_take),
        .item_kind    (s_axis_tuser),
        .item_button  (s_axis_tdata[IDX_W-1:0]),
        .item_pressed (s_axis_tdata[IDX_W]),
        .result       (core_result)
    );

    kpirq_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (item_take),
        .push_data  (core_result),
        .push_ready (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (out_result),
        .status     (obuf_status)
    );

    // Upper bits of the result bus are zero fill.
    assign m_axis_tdata = M_DATA_W'(out_result);

    // The skid stage is only ever filled behind a full result register.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        obuf_status.skid_valid |-> obuf_status.main_valid)
        else $error("skid entry held with empty result register");

    // An item taken while the result register is stalled must land in skid.
    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (item_take && obuf_status.main_valid && !m_axis_tready) |=>
        obuf_status.skid_valid)
        else $error("item taken under stall was not kept");

    // Opposite directions are never held together.
    a_no_right_left: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[KEY_RIGHT] || m_axis_tdata[KEY_LEFT]))
        else $error("right and left held together");

    a_no_up_down: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[KEY_UP] || m_axis_tdata[KEY_DOWN]))
        else $error("up and down held together");

endmodule

### verif/keypad_state_and_irq_unit_tb.sv
// ----------------------------------------------------------------------------
// Keypad state and interrupt request unit testbench
// Sends button, check-only and out-of-range items through the slave stream
// under several interrupt settings and compares every result item with a
// cycle-free prediction of the key register and the request pulse.
// ----------------------------------------------------------------------------
module testbench;

    import kpirq_pkg::*;

    // Clock, reset and the ports of the unit.
    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata;   // [3:0] button_index, [4] pressed
    logic                 s_axis_tuser;   // [0] kind
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_axis_tdata;   // [9:0] key_bits, [10] irq_request

    // Shadow copy of the configuration registers.
    logic     irq_on;
    logic     need_all_keys;
    key_vec_t watched_keys;

    // Shadow copy of the key state.
    key_vec_t keys_now;
    key_vec_t released_opposites;
    logic     condition_seen;

    // Results that the unit still owes, oldest first.
    result_t  pending_results[$];

    // When set, neither side idles.
    logic     steady = 1'b0;

    int       items_sent;
    int       results_seen;
    int       requests_seen;
    int       error_count;

    keypad_state_and_irq_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The receiver stalls with a chance of roughly 29 in a hundred unless the
    // current phase runs steady.
    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(99) >= 29);
    end

    // Applies one accepted item to the shadow state and returns the result
    // the unit must produce for it. Pressing a direction releases the
    // opposite one and remembers it if it was held; releasing the direction
    // presses the remembered opposite again.
    function automatic result_t next_key_result(input logic kind,
                                                input logic [IDX_W-1:0] button,
                                                input logic pressed);
        key_vec_t key_bit;
        key_vec_t opposite;
        key_vec_t held;
        logic     condition;
        result_t  outcome;
        if (kind == KIND_BUTTON && button < KEY_COUNT)
        begin
            key_bit  = key_vec_t'(1) << button;
            opposite = '0;
            if (button == KEY_UP || button == KEY_RIGHT)
                opposite = key_bit << 1;
            else if (button == KEY_DOWN || button == KEY_LEFT)
                opposite = key_bit >> 1;
            if (pressed)
            begin
                released_opposites |= ~keys_now & opposite;
                keys_now = (keys_now | opposite) & ~key_bit;
            end
            else
            begin
                if (opposite != '0)
                begin
                    released_opposites &= ~key_bit;
                    keys_now &= ~(released_opposites & opposite);
                    released_opposites &= ~opposite;
                end
                keys_now |= key_bit;
            end
        end
        // An empty selection in all mode counts as satisfied.
        held = watched_keys & ~keys_now;
        condition = irq_on && (need_all_keys ? (held == watched_keys) : (held != '0));
        outcome.irq_request = condition && !condition_seen;
        outcome.key_bits = keys_now;
        condition_seen = condition;
        return outcome;
    endfunction

    // Offers one item, idling first at random, and records its expected
    // result once the unit takes it. The valid stays high on return so that
    // back-to-back items need no gap.
    task automatic send_item(input logic kind, input logic [IDX_W-1:0] button,
                             input logic pressed);
        while (!steady && $urandom_range(99) < 29)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, pressed, button};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(next_key_result(kind, button, pressed));
        items_sent++;
    endtask

    // Stops the sender and waits until every owed result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            CFG_IRQ_ENABLE:     irq_on = value[0];
            CFG_IRQ_ALL_MODE:   need_all_keys = value[0];
            CFG_IRQ_KEY_SELECT: watched_keys = value;
            default: ;
        endcase
    endtask

    // Rewrites all three registers; only called with nothing in flight.
    task automatic set_config(input logic enable, input logic all_mode,
                              input key_vec_t selection);
        wait_drained();
        write_reg(CFG_IRQ_ENABLE, CFG_W'(enable));
        write_reg(CFG_IRQ_ALL_MODE, CFG_W'(all_mode));
        write_reg(CFG_IRQ_KEY_SELECT, selection);
        cfg_we <= 1'b0;
    endtask

    // Result checker: each accepted result item is matched against the
    // oldest owed result, field by field.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[KEY_COUNT:0]);
            results_seen++;
            if (got.irq_request)
                requests_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result key_bits %h irq_request %b",
                         $time, got.key_bits, got.irq_request);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.key_bits !== want.key_bits)
                begin
                    $display("%0t: key_bits expected %h actual %h",
                             $time, want.key_bits, got.key_bits);
                    error_count++;
                end
                if (got.irq_request !== want.irq_request)
                begin
                    $display("%0t: irq_request expected %b actual %b",
                             $time, want.irq_request, got.irq_request);
                    error_count++;
                end
            end
        end
    end

    // Right after reset the keys read all released and no request is made.
    task automatic test_after_reset();
        send_item(KIND_CHECK, KEY_A, 1'b0);
    endtask

    // Non-directional keys at both ends of the register, out-of-range
    // buttons and a check-only item whose other fields must be ignored.
    task automatic test_plain_keys();
        set_config(1'b1, 1'b0, '1);
        send_item(KIND_BUTTON, KEY_A, 1'b1);
        send_item(KIND_BUTTON, KEY_L, 1'b1);
        send_item(KIND_BUTTON, KEY_A, 1'b0);
        send_item(KIND_BUTTON, KEY_L, 1'b0);
        send_item(KIND_BUTTON, 4'd15, 1'b1);
        send_item(KIND_BUTTON, 4'd10, 1'b0);
        send_item(KIND_CHECK, KEY_RIGHT, 1'b1);
    endtask

    // Opposite directions: the later press wins, and releasing it brings
    // back the one the player still holds.
    task automatic test_direction_pairs();
        set_config(1'b0, 1'b0, '0);
        send_item(KIND_BUTTON, KEY_LEFT, 1'b1);
        send_item(KIND_BUTTON, KEY_RIGHT, 1'b1);
        send_item(KIND_BUTTON, KEY_RIGHT, 1'b0);
        send_item(KIND_BUTTON, KEY_LEFT, 1'b0);
        send_item(KIND_BUTTON, KEY_DOWN, 1'b1);
        send_item(KIND_BUTTON, KEY_UP, 1'b1);
        send_item(KIND_BUTTON, KEY_DOWN, 1'b0);
        send_item(KIND_BUTTON, KEY_UP, 1'b0);
    endtask

    // All mode with an empty selection, all mode with two keys, and the
    // condition held off by a disabled interrupt.
    task automatic test_condition_modes();
        set_config(1'b1, 1'b1, '0);
        send_item(KIND_CHECK, KEY_A, 1'b0);
        send_item(KIND_CHECK, KEY_A, 1'b0);
        set_config(1'b1, 1'b1, 10'h003);
        send_item(KIND_BUTTON, KEY_A, 1'b1);
        send_item(KIND_BUTTON, KEY_B, 1'b1);
        send_item(KIND_BUTTON, KEY_B, 1'b0);
        set_config(1'b0, 1'b0, '1);
        send_item(KIND_BUTTON, KEY_B, 1'b1);
        send_item(KIND_BUTTON, KEY_A, 1'b0);
    endtask

    // Mostly real key presses and releases, with a share of check-only and
    // out-of-range items as noise. The press bias controls how many keys
    // end up held, which decides how often all-mode conditions come true.
    task automatic random_play(input int count, input int press_bias,
                               input int pause_every);
        int roll;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
                send_item(KIND_CHECK, IDX_W'($urandom_range(15)), 1'($urandom));
            else if (roll < 14)
                send_item(KIND_BUTTON, IDX_W'($urandom_range(15, KEY_COUNT)),
                          1'($urandom));
            else
                send_item(KIND_BUTTON, IDX_W'($urandom_range(KEY_COUNT - 1)),
                          $urandom_range(99) < press_bias);
            if (pause_every != 0 && n % pause_every == pause_every - 1)
                wait_drained();
        end
    endtask

    // Several settings in turn, the extremes among them. One phase runs
    // with no idling on either side, another holds the sender back until
    // every result has arrived.
    task automatic test_random_play();
        key_vec_t single_key;
        single_key = key_vec_t'(1) << $urandom_range(KEY_COUNT - 1);
        set_config(1'b1, 1'b0, single_key);
        random_play(85, 50, 0);
        set_config(1'b1, 1'b1, key_vec_t'($urandom) & key_vec_t'($urandom));
        random_play(85, 70, 0);
        set_config(1'b1, 1'b1, '1);
        random_play(85, 85, 0);
        steady = 1'b1;
        set_config(1'b0, 1'b0, '0);
        random_play(80, 50, 0);
        steady = 1'b0;
        set_config(1'b1, 1'b0, '1);
        random_play(85, 40, 25);
        set_config(1'($urandom), 1'($urandom), key_vec_t'($urandom));
        random_play(85, 60, 0);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_IRQ_ENABLE;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_BUTTON;
        irq_on             = 1'b0;
        need_all_keys      = 1'b0;
        watched_keys       = '0;
        keys_now           = '1;
        released_opposites = '0;
        condition_seen     = 1'b0;
        items_sent    = 0;
        results_seen  = 0;
        requests_seen = 0;
        error_count   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_plain_keys();
        test_direction_pairs();
        test_condition_modes();
        test_random_play();

        // Let the last result out, then give any stray result time to appear.
        wait_drained();
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived",
                     $time, pending_results.size());
            error_count++;
        end
        $display("Covered %0d items and %0d results, %0d interrupt requests,",
                 items_sent, results_seen, requests_seen);
        $display("across directed key cases and six random interrupt settings.");
        if (error_count == 0)
            $display("keypad_state_and_irq_unit test passed");
        else
            $display("keypad_state_and_irq_unit test failed");
        $finish;
    end

    // A guard timer, set far beyond the length of the whole run.
    initial
    begin
        #4000000;
        $display("%0t: timeout", $time);
        $display("keypad_state_and_irq_unit test failed");
        $finish;
    end

endmodule

### keypad_state_and_irq_unit.f
hw/rtl/kpirq_pkg.sv
hw/rtl/kpirq_core.sv
hw/rtl/kpirq_obuf.sv
hw/rtl/keypad_state_and_irq_unit.sv
verif/keypad_state_and_irq_unit_tb.sv
